// ===== sv/assert_macros.svh =====
// assertion macros used by barcode_prefix_counter
// no dependencies; expects a clock named i_clk and an active-low reset i_rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bpc_pkg.sv =====
// types, constants and helper functions for the barcode prefix counter
// no dependencies
package bpc_pkg;

    localparam int MAX_LENGTH = 8;
    localparam int LEN_W      = 4;
    localparam int LIDX_W     = 3;
    localparam int CODE_W     = 2 * MAX_LENGTH;
    localparam int CNT_W      = 32;
    localparam int TBL_DEPTH  = ((1 << (2 * (MAX_LENGTH + 1))) - 4) / 3;
    localparam int ADDR_W     = $clog2(TBL_DEPTH);
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_BARCODE_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PREFIX  = 1'b1;

    localparam logic [CFG_W-1:0] BARCODE_LEN_RST = 4'd8;
    localparam logic [CFG_W-1:0] MIN_PREFIX_RST  = 4'd5;

    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_C_UP = 8'h43;
    localparam logic [7:0] CH_G_UP = 8'h47;
    localparam logic [7:0] CH_T_UP = 8'h54;
    localparam logic [7:0] CH_N_UP = 8'h4E;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_C_LO = 8'h63;
    localparam logic [7:0] CH_G_LO = 8'h67;
    localparam logic [7:0] CH_T_LO = 8'h74;

    typedef enum logic [1:0] {
        K_COUNT   = 2'd0,
        K_QCOUNT  = 2'd1,
        K_QMAX    = 2'd2,
        K_UNUSED  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_BAD_LEN = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]        status;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  max_count;
        logic [CODE_W-1:0] full_code;
    } t_result;

    // saturate a register value into 1..MAX_LENGTH
    function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (v > CFG_W'(MAX_LENGTH)) begin
            r = LEN_W'(MAX_LENGTH);
        end else begin
            r = LEN_W'(v);
        end
        return r;
    endfunction

    // 2-bit value of one ascii base
    function automatic logic [1:0] base_code(input logic [7:0] ch, input logic [1:0] rnd);
        logic [1:0] r;
        case (ch)
            CH_A_UP, CH_A_LO: r = 2'd0;
            CH_C_UP, CH_C_LO: r = 2'd1;
            CH_G_UP, CH_G_LO: r = 2'd2;
            CH_T_UP, CH_T_LO: r = 2'd3;
            CH_N_UP:          r = rnd;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    // first slot of the table for prefix length len
    function automatic logic [ADDR_W-1:0] tbl_base(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] r;
        case (len)
            4'd1:    r = ADDR_W'(0);
            4'd2:    r = ADDR_W'(4);
            4'd3:    r = ADDR_W'(20);
            4'd4:    r = ADDR_W'(84);
            4'd5:    r = ADDR_W'(340);
            4'd6:    r = ADDR_W'(1364);
            4'd7:    r = ADDR_W'(5460);
            4'd8:    r = ADDR_W'(21844);
            default: r = '0;
        endcase
        return r;
    endfunction

    // keep the top len base codes of a packed word, right aligned
    function automatic logic [CODE_W-1:0] prefix_of(input logic [CODE_W-1:0] vals,
                                                    input logic [LEN_W-1:0] len);
        logic [LEN_W:0] sh;
        sh = (LEN_W+1)'(CODE_W) - {len, 1'b0};
        return vals >> sh;
    endfunction

endpackage

// ===== sv/barcode_prefix_counter.sv =====
// barcode prefix counter: sequencer, count table memory and per-length maxima
// depends on bpc_pkg and assert_macros.svh
//
// Usage
//   input channel i_in_valid / o_in_ready carries one item: a read to count
//   (kind 0) or a query for one count (kind 1) or one length's maximum (kind 2).
//   output channel o_out_valid / i_out_ready returns exactly one result per item.
//   i_cfg_we writes barcode_length (index 0) or min_prefix_length (index 1);
//   write only while no item is in flight.
// Sequence
//   a counted read does one read-modify-write of the count memory per prefix
//   length, one length a cycle, over barcode_length - min_prefix_length + 1
//   lengths in S_COUNT, then passes S_DRAIN and S_DONE; short reads, bad-length
//   and maximum queries go straight to S_DONE, valid count queries pass S_QUERY
//   and S_QWAIT (registered read). the next item is taken only back in S_IDLE.
// Reset
//   after reset a clearing pass zeroes the 87380-entry count memory, one entry
//   a cycle; o_in_ready stays low until the pass ends. maxima clear at once.
// Stalls
//   a finished result waits in the output register; a new item is accepted
//   meanwhile, and its result waits until the held one has been taken.
module barcode_prefix_counter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_kind,
    input  logic [63:0]                   i_bases,
    input  logic [7:0]                    i_read_length,
    input  logic [15:0]                   i_random_bits,
    input  logic [3:0]                    i_query_length,
    input  logic [15:0]                   i_query_code,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [31:0]                   o_count,
    output logic [31:0]                   o_max_count,
    output logic [15:0]                   o_full_code
);
    import bpc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_COUNT,
        S_DRAIN,
        S_QUERY,
        S_QWAIT,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [CFG_W-1:0]    r_bl;
    logic [CFG_W-1:0]    r_ml;
    logic [LEN_W-1:0]    r_len;
    logic [LEN_W-1:0]    r_last;
    logic [CODE_W-1:0]   r_vals;
    logic [ADDR_W-1:0]   r_q_addr;
    t_result             r_pend;
    t_result             r_out;
    logic                r_out_valid;
    logic                r_wr_v;
    logic [ADDR_W-1:0]   r_wr_addr;
    logic [LIDX_W-1:0]   r_wr_idx;
    logic [CNT_W-1:0]    r_rdata;
    logic [CNT_W-1:0]    r_lmax [MAX_LENGTH];
    logic [CNT_W-1:0]    mem [TBL_DEPTH];

    logic [LEN_W-1:0]    bl_c;
    logic [LEN_W-1:0]    ml_c;
    logic [CODE_W-1:0]   in_vals;
    logic [CODE_W-1:0]   q_mask;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CNT_W-1:0]    wr_data;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_wa;
    logic [CNT_W-1:0]    mem_wd;
    logic [LIDX_W-1:0]   q_idx;
    t_result             n_pend;
    t_state              n_state;
    logic                out_load;

    always_comb begin
        bl_c = clamp_len(r_bl);
        ml_c = clamp_len(r_ml);
        for (int j = 0; j < MAX_LENGTH; j++) begin
            in_vals[CODE_W-1-2*j -: 2] = base_code(i_bases[63-8*j -: 8],
                                                   i_random_bits[2*j+1 -: 2]);
        end
        q_mask  = prefix_of('1, i_query_length);
        q_idx   = LIDX_W'(i_query_length - LEN_W'(1));
        rd_addr = (r_state == S_COUNT)
                ? tbl_base(r_len) + ADDR_W'(prefix_of(r_vals, r_len))
                : r_q_addr;
        // saturating increment of the registered memory read data
        wr_data = (r_rdata == '1) ? r_rdata : r_rdata + CNT_W'(1);
        mem_we  = (r_state == S_CLEAR) || r_wr_v;
        mem_wa  = (r_state == S_CLEAR) ? r_clr_addr : r_wr_addr;
        mem_wd  = (r_state == S_CLEAR) ? '0 : wr_data;
        out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

        // pending result and next state for an item offered in idle
        n_pend  = '0;
        n_state = S_DONE;
        case (t_kind'(i_kind))
            K_COUNT: begin
                if (i_read_length < 8'(bl_c)) begin
                    n_pend.status = ST_SHORT;
                end else begin
                    n_pend.full_code = prefix_of(in_vals, bl_c);
                    if (ml_c <= bl_c) begin
                        n_state = S_COUNT;
                    end
                end
            end
            K_QCOUNT, K_QMAX: begin
                if (i_query_length == '0 ||
                    i_query_length > LEN_W'(MAX_LENGTH)) begin
                    n_pend.status = ST_BAD_LEN;
                end else begin
                    n_pend.max_count = r_lmax[q_idx];
                    if (t_kind'(i_kind) == K_QCOUNT) begin
                        n_state = S_QUERY;
                    end
                end
            end
            default: ;
        endcase
    end

    // count memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_bl        <= BARCODE_LEN_RST;
            r_ml        <= MIN_PREFIX_RST;
            r_out_valid <= 1'b0;
            r_wr_v      <= 1'b0;
            for (int k = 0; k < MAX_LENGTH; k++) begin
                r_lmax[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BARCODE_LEN: r_bl <= i_cfg_data;
                    REG_MIN_PREFIX:  r_ml <= i_cfg_data;
                    default: ;
                endcase
            end

            // write-back stage, one length behind the read
            r_wr_v    <= (r_state == S_COUNT);
            r_wr_addr <= rd_addr;
            r_wr_idx  <= LIDX_W'(r_len - LEN_W'(1));
            if (r_wr_v && (r_lmax[r_wr_idx] < wr_data)) begin
                r_lmax[r_wr_idx] <= wr_data;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(TBL_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pend   <= n_pend;
                        r_vals   <= in_vals;
                        r_len    <= ml_c;
                        r_last   <= bl_c;
                        r_q_addr <= tbl_base(i_query_length) + ADDR_W'(i_query_code & q_mask);
                        r_state  <= n_state;
                    end
                end
                S_COUNT: begin
                    if (r_len == r_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_len <= r_len + LEN_W'(1);
                    end
                end
                S_DRAIN: r_state <= S_DONE;
                S_QUERY: r_state <= S_QWAIT;
                S_QWAIT: begin
                    r_pend.count <= r_rdata;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out   <= r_pend;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out.status;
    assign o_count     = r_out.count;
    assign o_max_count = r_out.max_count;
    assign o_full_code = r_out.full_code;

`include "assert_macros.svh"

    `ASSERT_IMPL(a_wb_in_run, r_wr_v, r_state == S_COUNT || r_state == S_DRAIN, "stray write-back")
    `ASSERT_IMPL(a_no_wrap, r_wr_v, wr_data != '0, "count wrapped to zero")
    `ASSERT_IMPL(a_short_code, o_out_valid && o_status == ST_SHORT, o_full_code == '0, "short code")
    `ASSERT_IMPL(a_err_cnt, o_out_valid && o_status != ST_OK, ~|{o_count, o_max_count}, "err counts")
    `ASSERT_NEXT(a_drain_done, r_state == S_DRAIN, r_state == S_DONE && !r_wr_v, "drain overran")

endmodule
